### rtl/two_level_page_table_insert_top_macros.svh
// Assertion macros shared by the page table insert checker.
// No dependencies; include by bare file name.
`ifndef TWO_LEVEL_PAGE_TABLE_INSERT_TOP_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_INSERT_TOP_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define TLPT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define TLPT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    `TLPT_ASSERT(label, clk, rst_n, (cond), msg)

`endif

### rtl/tlpt_pkg.sv
// Package for the two-level page table insert block: sizes, entry layout,
// item structs and sequencer states. No dependencies.
package tlpt_pkg;

    localparam int TABLE_PAGES = 64;
    localparam int IDX_W       = 10;
    localparam int PPN_W       = 20;
    localparam int PTE_W       = 32;
    localparam int PAGE_SHIFT  = 12;
    localparam int DIR_DEPTH   = 1 << IDX_W;
    localparam int LEAF_DEPTH  = TABLE_PAGES * DIR_DEPTH;
    localparam int TPAGE_W     = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int USED_W      = $clog2(TABLE_PAGES + 1);
    localparam int TPOUT_W     = 6;
    localparam int LEAF_AW     = TPAGE_W + IDX_W;

    // Low flag field of each entry kind
    localparam logic [PAGE_SHIFT-1:0] DIR_FLAGS  = PAGE_SHIFT'(12'h001);
    localparam logic [PAGE_SHIFT-1:0] LEAF_FLAGS = PAGE_SHIFT'(12'h00F);

    localparam logic STATUS_MAPPED   = 1'b0;
    localparam logic STATUS_NO_TABLE = 1'b1;

    typedef struct packed {
        logic [PPN_W-1:0] virt_page_number;
        logic [PPN_W-1:0] phys_page_number;
    } t_in_item;

    typedef struct packed {
        logic               status;
        logic               new_table;
        logic [IDX_W-1:0]   dir_index;
        logic [PTE_W-1:0]   dir_entry;
        logic [TPOUT_W-1:0] table_page;
        logic [IDX_W-1:0]   leaf_index;
        logic [PTE_W-1:0]   leaf_entry;
    } t_out_item;

    typedef struct packed {
        logic               dir_we;
        logic               leaf_we;
        logic [LEAF_AW-1:0] leaf_addr;
        logic               alloc;
    } t_walk_ctrl;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

### rtl/two_level_page_table_insert_top.sv
// Two-level page table insert: sequencer, directory and leaf table memories.
// Depends on tlpt_pkg, tlpt_ram and tlpt_walk.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries map requests:
//   a virtual page number and the physical page to map it to. Output channel
//   (o_out_valid / i_out_stall / o_out_item) returns one result item per
//   request. i_cfg_wr_en / i_cfg_wr_data set the table page pool base; write
//   it only while no request is in flight.
//   Timing: a request is accepted, the directory entry comes back from the
//   directory memory in the next cycle, and the directory/leaf writes and
//   the result register load happen together once the result register is free.
//   Each item is a read-modify-write of the directory memory; the result is
//   registered behind the directory read. The next request is taken once the
//   result is registered, even if it has not yet been picked up.
//   Reset: the directory is cleared by a pass over all 1024 entries, one entry per
//   cycle, with o_in_stall high throughout; the pool counter and base clear.
//   Stall: if a result is still waiting when the next one is ready, the
//   lookup holds and the input stays stalled until the output is taken.
module two_level_page_table_insert_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tlpt_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tlpt_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_wr_en,
    input  logic [tlpt_pkg::PPN_W-1:0]     i_cfg_wr_data
);
    import tlpt_pkg::*;

    t_state              r_state, n_state;
    t_in_item            r_item;
    t_out_item           r_out_item;
    logic                r_out_valid, n_out_valid;
    logic [PPN_W-1:0]    r_pool_base;
    logic [USED_W-1:0]   r_pages_used;
    logic [IDX_W-1:0]    r_clr_idx;

    logic                in_accept;
    logic                load_out;
    logic                dir_we;
    logic [IDX_W-1:0]    dir_waddr;
    logic [PTE_W-1:0]    dir_wdata;
    logic [PTE_W-1:0]    dir_rdata;
    t_out_item           walk_result;
    t_walk_ctrl          walk_ctrl;

    assign in_accept = i_in_valid && (r_state == ST_IDLE);

    tlpt_ram #(
        .WIDTH (PTE_W),
        .DEPTH (DIR_DEPTH)
    ) u_dir_ram (
        .i_clk     (i_clk),
        .i_wr_en   (dir_we),
        .i_wr_addr (dir_waddr),
        .i_wr_data (dir_wdata),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_in_item.virt_page_number[PPN_W-1 -: IDX_W]),
        .o_rd_data (dir_rdata)
    );

    tlpt_walk u_walk (
        .i_item       (r_item),
        .i_dir_entry  (dir_rdata),
        .i_pool_base  (r_pool_base),
        .i_pages_used (r_pages_used),
        .o_result     (walk_result),
        .o_ctrl       (walk_ctrl)
    );

    // Leaf tables are write-only from this block's view
    tlpt_ram #(
        .WIDTH (PTE_W),
        .DEPTH (LEAF_DEPTH)
    ) u_leaf_ram (
        .i_clk     (i_clk),
        .i_wr_en   (load_out && walk_ctrl.leaf_we),
        .i_wr_addr (walk_ctrl.leaf_addr),
        .i_wr_data (walk_result.leaf_entry),
        .i_rd_en   (1'b0),
        .i_rd_addr ('0),
        .o_rd_data ()
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        load_out    = 1'b0;
        dir_we      = 1'b0;
        dir_waddr   = r_clr_idx;
        dir_wdata   = '0;

        case (r_state)
            ST_CLEAR: begin
                dir_we = 1'b1;
                if (r_clr_idx == IDX_W'(DIR_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // hold until the result register is free
                if (!r_out_valid || !i_out_stall) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    dir_we      = walk_ctrl.dir_we;
                    dir_waddr   = walk_result.dir_index;
                    dir_wdata   = walk_result.dir_entry;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_out_valid  <= 1'b0;
            r_pool_base  <= '0;
            r_pages_used <= '0;
            r_clr_idx    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_pool_base <= i_cfg_wr_data;
            end
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (load_out && walk_ctrl.alloc) begin
                r_pages_used <= r_pages_used + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_item;
        end
        if (load_out) begin
            r_out_item <= walk_result;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/tlpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module tlpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/tlpt_walk.sv
// Directory entry decode and table page allocation for one map request.
// Depends on tlpt_pkg.
module tlpt_walk (
    input  tlpt_pkg::t_in_item              i_item,
    input  logic [tlpt_pkg::PTE_W-1:0]      i_dir_entry,
    input  logic [tlpt_pkg::PPN_W-1:0]      i_pool_base,
    input  logic [tlpt_pkg::USED_W-1:0]     i_pages_used,
    output tlpt_pkg::t_out_item             o_result,
    output tlpt_pkg::t_walk_ctrl            o_ctrl
);
    import tlpt_pkg::*;

    logic [IDX_W-1:0] dir_idx;
    logic [IDX_W-1:0] leaf_idx;
    logic [PPN_W-1:0] used_ext;
    logic [PPN_W-1:0] alloc_pg;
    logic [PPN_W-1:0] held_idx;

    assign dir_idx  = i_item.virt_page_number[PPN_W-1 -: IDX_W];
    assign leaf_idx = i_item.virt_page_number[IDX_W-1:0];
    assign used_ext = PPN_W'(i_pages_used);
    // Both wrap modulo 2^20
    assign alloc_pg = i_pool_base + used_ext;
    assign held_idx = i_dir_entry[PTE_W-1:PAGE_SHIFT] - i_pool_base;

    always_comb begin
        logic [PPN_W-1:0] tpage;
        logic             fail;
        logic             fresh;
        logic [PTE_W-1:0] entry;

        tpage = '0;
        fail  = 1'b0;
        fresh = 1'b0;
        entry = i_dir_entry;

        if (i_dir_entry == '0) begin
            if (i_pages_used >= USED_W'(TABLE_PAGES)) begin
                fail = 1'b1;
            end else begin
                fresh = 1'b1;
                tpage = used_ext;
                entry = {alloc_pg, DIR_FLAGS};
            end
        end else if (held_idx >= used_ext) begin
            // entry points outside the pool as currently based
            fail = 1'b1;
        end else begin
            tpage = held_idx;
        end

        o_result.status     = fail ? STATUS_NO_TABLE : STATUS_MAPPED;
        o_result.new_table  = fresh;
        o_result.dir_index  = dir_idx;
        o_result.dir_entry  = entry;
        o_result.table_page = fail ? '0 : tpage[TPOUT_W-1:0];
        o_result.leaf_index = leaf_idx;
        o_result.leaf_entry = fail ? '0 : {i_item.phys_page_number, LEAF_FLAGS};

        o_ctrl.dir_we    = fresh;
        o_ctrl.alloc     = fresh;
        o_ctrl.leaf_we   = !fail;
        o_ctrl.leaf_addr = {tpage[TPAGE_W-1:0], leaf_idx};
    end

endmodule

### rtl/tlpt_checker.sv
// Port-level assertions for the page table insert top level, bound to it.
// Depends on tlpt_pkg and two_level_page_table_insert_top_macros.svh.
`include "two_level_page_table_insert_top_macros.svh"

module tlpt_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  tlpt_pkg::t_out_item            o_out_item
);
    import tlpt_pkg::*;

    // A failed map writes nothing and reports no table or leaf
    `TLPT_ASSERT_ALWAYS(a_fail_clean, i_clk, i_rst_n, !(o_out_valid && o_out_item.status == STATUS_NO_TABLE && (o_out_item.new_table || o_out_item.table_page != '0 || o_out_item.leaf_entry != '0)), "failed map reports table or leaf")

    // A successful map carries valid directory and full-permission leaf flags
    `TLPT_ASSERT(a_map_flags, i_clk, i_rst_n, (o_out_valid && o_out_item.status == STATUS_MAPPED) |-> (o_out_item.dir_entry[PAGE_SHIFT-1:0] == DIR_FLAGS && o_out_item.leaf_entry[PAGE_SHIFT-1:0] == LEAF_FLAGS), "mapped result has wrong entry flags")

    // A fresh table is only reported on a successful map
    `TLPT_ASSERT(a_fresh_mapped, i_clk, i_rst_n, (o_out_valid && o_out_item.new_table) |-> (o_out_item.status == STATUS_MAPPED), "new table on failed map")

    // One request at a time: input stalls right after acceptance
    `TLPT_ASSERT(a_one_inflight, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "input not stalled during lookup")

    // Stalled result holds
    `TLPT_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)), "stalled result changed")

endmodule

bind two_level_page_table_insert_top tlpt_checker u_tlpt_checker (.*);

### tb/sv/two_level_page_table_insert_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for two_level_page_table_insert_top: drives map requests in bursts,
// keeps a shadow directory and pool counter to predict each result item, and checks them.
// Depends on tlpt_pkg and the block's RTL.
module two_level_page_table_insert_top_test;
    import tlpt_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_wr_en = 1'b0;
    logic [PPN_W-1:0]     cfg_wr_data = '0;

    // shadow of the block's state
    logic [PTE_W-1:0]     dir_shadow [DIR_DEPTH];
    int                   pages_taken = 0;
    logic [PPN_W-1:0]     pool_base = '0;
    logic [IDX_W-1:0]     alloc_dirs [$];

    t_out_item            map_results [$];
    int                   errors = 0;
    int                   results_seen = 0;
    int                   tables_seen = 0;
    int                   refused_seen = 0;
    int                   burst_left = 0;
    logic [PPN_W-1:0]     base_home;

    // receiver stall pattern
    int                   stall_mode = 0;
    int                   stall_run = 0;
    int unsigned          cyc = 0;

    two_level_page_table_insert_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_item     (in_item),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_item    (out_item),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #10 clk = ~clk;

    initial begin
        for (int i = 0; i < DIR_DEPTH; i++) begin
            dir_shadow[i] = '0;
        end
    end

    // Work out the result of one map request and advance the shadow state.
    function automatic t_out_item predict_map(input t_in_item req);
        t_out_item        r;
        logic [IDX_W-1:0] di;
        logic [PTE_W-1:0] ent;
        logic [PPN_W-1:0] pg;
        logic [PPN_W-1:0] slot;
        r = '0;
        di = req.virt_page_number[PPN_W-1:IDX_W];
        ent = dir_shadow[di];
        r.status = STATUS_MAPPED;
        r.dir_index = di;
        r.leaf_index = req.virt_page_number[IDX_W-1:0];
        if (ent == '0) begin
            if (pages_taken >= TABLE_PAGES) begin
                r.status = STATUS_NO_TABLE;
            end else begin
                pg = pool_base + PPN_W'(pages_taken);
                r.table_page = TPOUT_W'(pages_taken);
                pages_taken++;
                ent = {pg, DIR_FLAGS};
                dir_shadow[di] = ent;
                alloc_dirs.push_back(di);
                r.new_table = 1'b1;
            end
        end else begin
            slot = ent[PTE_W-1:PAGE_SHIFT] - pool_base;
            if (int'(slot) >= pages_taken) begin
                r.status = STATUS_NO_TABLE;
            end else begin
                r.table_page = TPOUT_W'(slot);
            end
        end
        r.dir_entry = ent;
        if (r.status == STATUS_MAPPED) begin
            r.leaf_entry = {req.phys_page_number, LEAF_FLAGS};
        end else begin
            r.table_page = '0;
        end
        return r;
    endfunction

    function automatic t_in_item map_req(input logic [PPN_W-1:0] vpn, input logic [PPN_W-1:0] ppn);
        t_in_item r;
        r.virt_page_number = vpn;
        r.phys_page_number = ppn;
        return r;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the item.
    task automatic send_map(input t_in_item req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (in_stall);
        map_results.push_back(predict_map(req));
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (map_results.size() != 0);
    endtask

    task automatic write_pool_base(input logic [PPN_W-1:0] base);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= base;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pool_base = base;
    endtask

    task automatic compare_field(input string name, input logic [PTE_W-1:0] want,
                                 input logic [PTE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (map_results.size() == 0) begin
                $display("%0t: result item with none expected, expected nothing, got %h",
                         $time, out_item);
                errors++;
            end else begin
                want = map_results.pop_front();
                compare_field("status", PTE_W'(want.status), PTE_W'(out_item.status));
                compare_field("new_table", PTE_W'(want.new_table),
                              PTE_W'(out_item.new_table));
                compare_field("dir_index", PTE_W'(want.dir_index),
                              PTE_W'(out_item.dir_index));
                compare_field("dir_entry", want.dir_entry, out_item.dir_entry);
                compare_field("table_page", PTE_W'(want.table_page),
                              PTE_W'(out_item.table_page));
                compare_field("leaf_index", PTE_W'(want.leaf_index),
                              PTE_W'(out_item.leaf_index));
                compare_field("leaf_entry", want.leaf_entry, out_item.leaf_entry);
                results_seen++;
                if (want.new_table) tables_seen++;
                if (want.status == STATUS_NO_TABLE) refused_seen++;
            end
        end
    end

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_run  <= $urandom_range(8, 60);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0: begin
                out_stall <= 1'b0;
            end
            1: begin
                out_stall <= 1'($urandom_range(0, 1));
            end
            2: begin
                out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                out_stall <= (cyc[2:0] < 3'd3);
            end
        endcase
    end

    // Field extremes, same-directory hits and leaf index corners.
    task automatic test_directed_corners();
        write_pool_base(20'h00000);
        send_map(map_req(20'h00000, 20'h00000));
        send_map(map_req(20'h00000, 20'hFFFFF));
        send_map(map_req(20'hFFFFF, 20'hFFFFF));
        send_map(map_req(20'hFFC00, 20'h55555));
        send_map(map_req(20'h003FF, 20'hAAAAA));
        send_map(map_req(20'hAAAAA, 20'h55555));
        send_map(map_req(20'h55555, 20'hAAAAA));
    endtask

    // Place the pool at the top of the page space so allocation wraps to zero.
    task automatic test_pool_wrap();
        write_pool_base(20'hFFFFF - PPN_W'(pages_taken));
        send_map(map_req({10'h123, 10'h001}, 20'h0F0F0));
        send_map(map_req({10'h321, 10'h3FE}, 20'hF0F0F));
        send_map(map_req({10'h123, 10'h3FF}, 20'h12345));
        write_pool_base(20'hFFFFF);
        send_map(map_req({10'h0F0, 10'h000}, 20'hFEDCB));
        send_map(map_req(20'h00010, 20'h00001));
    endtask

    // Move the pool so older directory entries name pages outside it.
    task automatic test_outside_pool();
        write_pool_base(20'h12345);
        send_map(map_req(20'h00005, 20'h11111));
        send_map(map_req(20'hFFC05, 20'h22222));
        send_map(map_req({10'h200, 10'h155}, 20'h33333));
        send_map(map_req({10'h200, 10'h2AA}, 20'h44444));
        send_map(map_req({10'h123, 10'h000}, 20'h55555));
    endtask

    // Mostly hits on allocated directory entries, some fresh and corner indexes.
    task automatic test_random_maps(input int count, input logic [PPN_W-1:0] base);
        int               sel;
        logic [IDX_W-1:0] di;
        logic [IDX_W-1:0] li;
        logic [PPN_W-1:0] ppn;
        write_pool_base(base);
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 19);
            if (sel < 15 && alloc_dirs.size() != 0) begin
                di = alloc_dirs[$urandom_range(0, alloc_dirs.size() - 1)];
            end else if (sel < 17) begin
                di = $urandom_range(0, 1) ? '1 : '0;
            end else begin
                di = IDX_W'($urandom_range(0, DIR_DEPTH - 1));
            end
            li = IDX_W'($urandom_range(0, DIR_DEPTH - 1));
            if ($urandom_range(0, 9) == 0) li = $urandom_range(0, 1) ? '1 : '0;
            ppn = PPN_W'($urandom_range(0, 20'hFFFFF));
            if ($urandom_range(0, 19) == 0) ppn = $urandom_range(0, 1) ? '1 : '0;
            send_map(map_req({di, li}, ppn));
            // hold input until the pipeline drains now and then
            if (n % 100 == 99) wait_results_drained();
        end
    endtask

    // Take fresh directory entries until the pool runs dry, then a few more.
    task automatic test_pool_exhaustion();
        logic [IDX_W-1:0] di;
        int               extra;
        extra = 0;
        while (extra < 3) begin
            if (pages_taken >= TABLE_PAGES) extra++;
            do di = IDX_W'($urandom_range(0, DIR_DEPTH - 1)); while (dir_shadow[di] != '0);
            send_map(map_req({di, 10'($urandom_range(0, DIR_DEPTH - 1))},
                             PPN_W'($urandom_range(0, 20'hFFFFF))));
        end
    endtask

    initial begin
        base_home = PPN_W'($urandom_range(0, 20'hFFFFF));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // hold through the directory clear pass
        do @(posedge clk); while (in_stall);
        test_directed_corners();
        test_pool_wrap();
        test_outside_pool();
        test_random_maps(450, base_home);
        test_pool_exhaustion();
        test_random_maps(200, base_home);
        test_random_maps(80, PPN_W'($urandom_range(0, 20'hFFFFF)));
        test_random_maps(200, base_home);
        wait_results_drained();
        repeat (8) @(posedge clk);
        $display("summary: %0d map results checked, %0d table pages allocated, %0d refused",
                 results_seen, tables_seen, refused_seen);
        $display("summary: pool bases at both extremes, wrapped, moved away and restored");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("timeout with %0d results outstanding", map_results.size());
        $display("tb: failure");
        $finish;
    end

endmodule
